// ===== src/rcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, codes and the generator step of the cycle chain builder.
// ----------------------------------------------------------------------------
package rcc_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_FILL,
        S_SH_RAND,
        S_SH_DIV,
        S_SH_RDI,
        S_SH_RDJ,
        S_SH_WRI,
        S_SH_WRJ,
        S_LK_RD,
        S_LK_WR,
        S_LK_LAST,
        S_RESP
    } t_state;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT  = 2'd2;

    localparam logic MODE_BUILD  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [7:0] CFG_SEED = 8'd0;
    localparam logic [7:0] CFG_SEQ  = 8'd1;

    localparam logic [63:0] SEED_RESET = 64'd20260818;

    // xorshift64 step: left 13, right 7, left 17
    function automatic logic [63:0] xorshift64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction

endpackage

// ===== src/random_cycle_chain_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_cycle_chain_builder
// Builds one cycle through N slots (shuffled or ascending), answers lookups.
// ----------------------------------------------------------------------------
// One item at a time. A build of N slots first fills the order memory, then
// in random mode makes N-1 swaps (each waiting on the bit-serial remainder
// unit, then reading and writing the order memory), then links successors.
// Invalid items go straight to the result. The next item is accepted as soon
// as a result is handed to the output register, even while that result waits.
// ----------------------------------------------------------------------------
module random_cycle_chain_builder #(
    parameter int MAX_LINES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [16:0] i_line_count,
    input  logic [15:0] i_slot_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_next_slot,
    output logic [1:0]  o_status
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    rcc_pkg::t_state r_state, n_state;

    logic [63:0]   r_seed;
    logic          r_seqord;
    logic [63:0]   r_gen;
    logic [CW-1:0] r_built;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_ti;
    logic [AW-1:0] r_prev;
    logic [AW-1:0] r_first;
    logic [15:0]   r_res_next;
    logic [1:0]    r_res_status;
    logic          r_out_valid;
    logic [15:0]   r_out_next;
    logic [1:0]    r_out_status;

    logic          accept;
    logic          out_free;
    logic          bad_count;
    logic          bad_slot;
    logic [31:0]   cnt_ext;
    logic [31:0]   slot_ext;
    logic [AW-1:0] slot_addr;
    logic [AW-1:0] last_idx;
    logic [63:0]   gen_step;
    logic [31:0]   rd_ext;

    logic          ord_we;
    logic [AW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic          suc_we;
    logic [AW-1:0] suc_waddr, suc_wdata, suc_raddr, suc_rdata;
    logic          div_start;
    logic          div_done;
    logic [CW-1:0] div_rem;

    assign accept    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cnt_ext   = 32'(i_line_count);
    assign slot_ext  = 32'(i_slot_index);
    assign slot_addr = slot_ext[AW-1:0];
    assign last_idx  = AW'(r_count - CW'(1));
    assign gen_step  = rcc_pkg::xorshift64(r_gen);
    assign rd_ext    = 32'(suc_rdata);

    assign bad_count = (cnt_ext < 32'd2) || (cnt_ext > 32'(MAX_LINES));
    assign bad_slot  = (r_built == '0) || (slot_ext >= 32'(r_built))
                    || (slot_ext >= 32'(MAX_LINES));

    rcc_ram #(.WIDTH(AW), .DEPTH(MAX_LINES)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    rcc_ram #(.WIDTH(AW), .DEPTH(MAX_LINES)) u_succ (
        .i_clk   (i_clk),
        .i_we    (suc_we),
        .i_waddr (suc_waddr),
        .i_wdata (suc_wdata),
        .i_raddr (suc_raddr),
        .o_rdata (suc_rdata)
    );

    rcc_rem #(.DIVW(CW)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (gen_step),
        .i_divisor  (CW'(r_i) + CW'(1)),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcc_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_mode == rcc_pkg::MODE_BUILD) begin
                        n_state = bad_count ? rcc_pkg::S_RESP : rcc_pkg::S_FILL;
                    end else begin
                        n_state = bad_slot ? rcc_pkg::S_RESP : rcc_pkg::S_LOOK;
                    end
                end
            end
            rcc_pkg::S_LOOK:    n_state = rcc_pkg::S_RESP;
            rcc_pkg::S_FILL: begin
                if (r_i == last_idx) begin
                    n_state = r_seqord ? rcc_pkg::S_LK_RD : rcc_pkg::S_SH_RAND;
                end
            end
            rcc_pkg::S_SH_RAND: n_state = rcc_pkg::S_SH_DIV;
            rcc_pkg::S_SH_DIV: begin
                if (div_done) begin
                    n_state = rcc_pkg::S_SH_RDI;
                end
            end
            rcc_pkg::S_SH_RDI:  n_state = rcc_pkg::S_SH_RDJ;
            rcc_pkg::S_SH_RDJ:  n_state = rcc_pkg::S_SH_WRI;
            rcc_pkg::S_SH_WRI:  n_state = rcc_pkg::S_SH_WRJ;
            rcc_pkg::S_SH_WRJ: begin
                n_state = (r_i == AW'(1)) ? rcc_pkg::S_LK_RD : rcc_pkg::S_SH_RAND;
            end
            rcc_pkg::S_LK_RD:   n_state = rcc_pkg::S_LK_WR;
            rcc_pkg::S_LK_WR: begin
                if (r_i == last_idx) begin
                    n_state = rcc_pkg::S_LK_LAST;
                end else begin
                    n_state = rcc_pkg::S_LK_RD;
                end
            end
            rcc_pkg::S_LK_LAST: n_state = rcc_pkg::S_RESP;
            rcc_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = rcc_pkg::S_IDLE;
                end
            end
            default:            n_state = rcc_pkg::S_IDLE;
        endcase
    end

    // memory and unit controls
    always_comb begin
        o_in_stall = (r_state != rcc_pkg::S_IDLE);
        ord_we     = 1'b0;
        ord_waddr  = r_i;
        ord_wdata  = r_i;
        ord_raddr  = r_i;
        suc_we     = 1'b0;
        suc_waddr  = r_prev;
        suc_wdata  = ord_rdata;
        suc_raddr  = slot_addr;
        div_start  = 1'b0;
        unique case (r_state)
            rcc_pkg::S_FILL:    ord_we = 1'b1;
            rcc_pkg::S_SH_RAND: div_start = 1'b1;
            rcc_pkg::S_SH_RDJ:  ord_raddr = r_j;
            rcc_pkg::S_SH_WRI: begin
                ord_we    = 1'b1;
                ord_wdata = ord_rdata;
            end
            rcc_pkg::S_SH_WRJ: begin
                ord_we    = 1'b1;
                ord_waddr = r_j;
                ord_wdata = r_ti;
            end
            rcc_pkg::S_LK_WR:   suc_we = (r_i != '0);
            rcc_pkg::S_LK_LAST: begin
                suc_we    = 1'b1;
                suc_wdata = r_first;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcc_pkg::S_IDLE;
            r_seed      <= rcc_pkg::SEED_RESET;
            r_seqord    <= 1'b0;
            r_built     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == rcc_pkg::CFG_SEED) begin
                    r_seed <= i_cfg_data;
                end else if (i_cfg_index == rcc_pkg::CFG_SEQ) begin
                    r_seqord <= i_cfg_data[0];
                end
            end
            if (r_state == rcc_pkg::S_LK_LAST) begin
                r_built <= r_count;
            end
            if (r_state == rcc_pkg::S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rcc_pkg::S_IDLE: begin
                r_res_next <= '0;
                r_count    <= CW'(cnt_ext);
                r_i        <= '0;
                r_gen      <= (r_seed == '0) ? 64'd1 : r_seed;
                if (i_mode == rcc_pkg::MODE_BUILD) begin
                    r_res_status <= bad_count ? rcc_pkg::ST_BAD_COUNT : rcc_pkg::ST_OK;
                end else begin
                    r_res_status <= bad_slot ? rcc_pkg::ST_BAD_SLOT : rcc_pkg::ST_OK;
                end
            end
            rcc_pkg::S_LOOK:   r_res_next <= rd_ext[15:0];
            rcc_pkg::S_FILL: begin
                if (r_i == last_idx) begin
                    r_i <= r_seqord ? '0 : last_idx;
                end else begin
                    r_i <= r_i + AW'(1);
                end
            end
            rcc_pkg::S_SH_RAND: r_gen <= gen_step;
            rcc_pkg::S_SH_DIV: begin
                if (div_done) begin
                    r_j <= AW'(div_rem);
                end
            end
            rcc_pkg::S_SH_RDJ:  r_ti <= ord_rdata;
            rcc_pkg::S_SH_WRJ:  r_i <= (r_i == AW'(1)) ? '0 : r_i - AW'(1);
            rcc_pkg::S_LK_WR: begin
                r_prev <= ord_rdata;
                if (r_i == '0) begin
                    r_first <= ord_rdata;
                end
                if (r_i != last_idx) begin
                    r_i <= r_i + AW'(1);
                end
            end
            rcc_pkg::S_RESP: begin
                if (out_free) begin
                    r_out_next   <= r_res_next;
                    r_out_status <= r_res_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_next_slot = r_out_next;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second beat accepted while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != rcc_pkg::ST_OK) |-> (o_next_slot == 16'd0))
        else $error("error result carries a slot");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    a_built_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_built == '0) || (r_built >= CW'(2)))
        else $error("built chain too short");
`endif

endmodule

// ===== src/rcc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rcc_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_rem
// Restoring remainder unit: 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcc_rem #(
    parameter int DIVW = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [63:0]     i_dividend,
    input  logic [DIVW-1:0] i_divisor,
    output logic            o_done,
    output logic [DIVW-1:0] o_rem
);

    logic            r_busy;
    logic            r_done;
    logic [5:0]      r_cnt;
    logic [63:0]     r_dvd;
    logic [DIVW-1:0] r_div;
    logic [DIVW-1:0] r_rem;
    logic [DIVW:0]   trial;
    logic [DIVW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[63]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = DIVW'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DIVW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== tb/random_cycle_chain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_cycle_chain_checker
// Watches the register port and both beat channels of the chain builder,
// keeps its own copy of the chain tables, predicts each result and compares.
// ----------------------------------------------------------------------------
module random_cycle_chain_checker #(
    parameter int MAX_LINES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_mode,
    input  logic [16:0] i_line_count,
    input  logic [15:0] i_slot_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_next_slot,
    input  logic [1:0]  i_status,
    output int          o_failures,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] next_slot;
        logic [1:0]  status;
    } t_answer;

    logic [15:0] visit_order [MAX_LINES];
    logic [15:0] successor [MAX_LINES];
    logic [63:0] prng;
    int          chain_len;
    logic [63:0] seed_reg;
    logic        ascending;
    t_answer     answers_due[$];

    function automatic logic [63:0] prng_step();
        logic [63:0] x;
        x = prng;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        prng = x;
        return x;
    endfunction

    function automatic void link_chain(input int n);
        int          j;
        logic [15:0] t;
        for (int i = 0; i < n; i++) visit_order[i] = 16'(i);
        if (!ascending) begin
            prng = (seed_reg == 64'd0) ? 64'd1 : seed_reg;
            for (int i = n - 1; i > 0; i--) begin
                j = int'(prng_step() % 64'(i + 1));
                t = visit_order[i];
                visit_order[i] = visit_order[j];
                visit_order[j] = t;
            end
        end
        for (int i = 0; i < n; i++)
            successor[visit_order[i]] = visit_order[(i + 1 == n) ? 0 : i + 1];
        chain_len = n;
    endfunction

    function automatic t_answer predict_answer(logic m, logic [16:0] cnt, logic [15:0] slot);
        t_answer a;
        a = '{next_slot: 16'd0, status: rcc_pkg::ST_OK};
        if (m == rcc_pkg::MODE_BUILD) begin
            if (cnt < 2 || cnt > MAX_LINES) a.status = rcc_pkg::ST_BAD_COUNT;
            else link_chain(int'(cnt));
        end else if (chain_len == 0 || int'(slot) >= chain_len) begin
            a.status = rcc_pkg::ST_BAD_SLOT;
        end else begin
            a.next_slot = successor[slot];
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        int      fails;
        fails = 0;
        if (!i_rst_n) begin
            answers_due.delete();
            chain_len  = 0;
            seed_reg   = rcc_pkg::SEED_RESET;
            ascending  = 1'b0;
            prng       = 64'd0;
            o_failures <= 0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rcc_pkg::CFG_SEED) seed_reg = i_cfg_data;
                else if (i_cfg_index == rcc_pkg::CFG_SEQ) ascending = i_cfg_data[0];
            end
            if (i_in_valid && !i_in_stall)
                answers_due.push_back(predict_answer(i_mode, i_line_count, i_slot_index));
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    fails++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_next_slot !== want.next_slot) begin
                        $error("next_slot: expected %0d, got %0d", want.next_slot, i_next_slot);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                end
            end
            o_failures <= o_failures + fails;
            o_pending  <= answers_due.size();
        end
    end

endmodule

// ===== tb/random_cycle_chain_builder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_cycle_chain_builder_tb
// Directed and random builds and lookups under several seeds, both ordering
// modes and varied sender/receiver idling; checking is done by the checker.
// ----------------------------------------------------------------------------
module random_cycle_chain_builder_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_mode = rcc_pkg::MODE_BUILD;
    logic [16:0] i_line_count = '0;
    logic [15:0] i_slot_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_next_slot;
    logic [1:0]  o_status;
    int          failures;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          built = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    random_cycle_chain_builder uut (.*);

    random_cycle_chain_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_mode, .i_line_count, .i_slot_index,
        .i_out_valid(o_out_valid), .i_out_stall, .i_next_slot(o_next_slot),
        .i_status(o_status), .o_failures(failures), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_beat(logic m, logic [16:0] cnt, logic [15:0] slot);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= m;
        i_line_count <= cnt;
        i_slot_index <= slot;
        // stall is stable between negedge and the next rising edge
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        if (m == rcc_pkg::MODE_BUILD && cnt >= 2 && cnt <= 65536) built = int'(cnt);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n_items, int idle, int stall);
        int          r;
        logic [16:0] cnt;
        drain();
        r = $urandom_range(9);
        write_reg(rcc_pkg::CFG_SEED, (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom});
        write_reg(rcc_pkg::CFG_SEQ, 64'($urandom_range(3) == 0));
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                cnt = ($urandom_range(7) == 0) ? 17'd2 : 17'($urandom_range(64, 2));
                send_beat(rcc_pkg::MODE_BUILD, cnt, 16'($urandom));
            end else if (r < 12) begin
                cnt = 17'($urandom);
                if (cnt >= 2 && cnt <= 65536) cnt = 17'h10000 + 17'($urandom_range(65535, 1));
                send_beat(rcc_pkg::MODE_BUILD, cnt, 16'($urandom));
            end else if (r < 85 && built > 0) begin
                send_beat(rcc_pkg::MODE_LOOKUP, 17'($urandom), 16'($urandom_range(built - 1)));
            end else begin
                send_beat(rcc_pkg::MODE_LOOKUP, 17'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lookup before any build, then counts out of range
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'd0);
        send_beat(rcc_pkg::MODE_BUILD, 17'd0, 16'd0);
        send_beat(rcc_pkg::MODE_BUILD, 17'd1, 16'd0);
        send_beat(rcc_pkg::MODE_BUILD, 17'h10001, 16'd0);
        send_beat(rcc_pkg::MODE_BUILD, 17'h1FFFF, 16'hFFFF);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'd1);
        // smallest chain with the reset seed
        send_beat(rcc_pkg::MODE_BUILD, 17'd2, 16'd0);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'd0);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'd1);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'd2);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'hFFFF);
        // full size, ascending
        drain();
        write_reg(rcc_pkg::CFG_SEQ, 64'd1);
        send_beat(rcc_pkg::MODE_BUILD, 17'h10000, 16'd0);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'hFFFF);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'h8000);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'h7FFF);
        // a rejected build keeps the previous chain
        send_beat(rcc_pkg::MODE_BUILD, 17'd1, 16'd0);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'hFFFF);
        // zero seed acts as one, then all-ones seed with a larger chain
        drain();
        write_reg(rcc_pkg::CFG_SEQ, 64'd0);
        write_reg(rcc_pkg::CFG_SEED, 64'd0);
        send_beat(rcc_pkg::MODE_BUILD, 17'd5, 16'd0);
        for (int s = 0; s < 6; s++) send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'(s));
        drain();
        write_reg(rcc_pkg::CFG_SEED, '1);
        send_beat(rcc_pkg::MODE_BUILD, 17'd300, 16'd0);
        send_beat(rcc_pkg::MODE_LOOKUP, 17'd0, 16'd299);

        random_phase(130, 0, 0);
        random_phase(130, 73, 0);
        random_phase(130, 0, 73);
        random_phase(130, 19, 19);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
